// ===== hw/rtl/multitrack_step_sequencer_unit_defines.svh =====
// Assertion macros for the multitrack step sequencer.
// Used by the top level only; expects clk_i and rst_ni in scope.
`ifndef MULTITRACK_STEP_SEQUENCER_UNIT_DEFINES_SVH
`define MULTITRACK_STEP_SEQUENCER_UNIT_DEFINES_SVH

`define MSS_ASSERT_IMP(lbl, ant, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (cons)) \
    else $error("mss: implication check failed");

`define MSS_ASSERT_NEXT(lbl, ant, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (cons)) \
    else $error("mss: next-cycle check failed");

`endif

// ===== hw/rtl/mss_pkg.sv =====
// Shared types and constants of the multitrack step sequencer.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package mss_pkg;
  localparam int NUM_TRACKS_DEF      = 16;
  localparam int MAX_PATTERN_LEN_DEF = 16;
  localparam int MAX_DIVIDE          = 32;
  localparam int MAX_BUS             = 28;
  localparam logic [31:0] LFSR_TAPS  = 32'hD000_0001;

  localparam logic [1:0] ACT_TICK    = 2'd0;
  localparam logic [1:0] ACT_TRACK   = 2'd1;
  localparam logic [1:0] ACT_PATTERN = 2'd2;

  localparam logic [1:0] DIR_FWD  = 2'd0;
  localparam logic [1:0] DIR_BWD  = 2'd1;
  localparam logic [1:0] DIR_RND  = 2'd2;
  localparam logic [1:0] DIR_HOLD = 2'd3;

  localparam logic [2:0] REG_INTERVAL = 3'd0;
  localparam logic [2:0] REG_RAND_EN  = 3'd1;
  localparam logic [2:0] REG_MASK     = 3'd2;
  localparam logic [2:0] REG_DEST     = 3'd3;
  localparam logic [2:0] REG_CLK_OUT  = 3'd4;
  localparam logic [2:0] REG_SEED     = 3'd5;

  typedef struct packed {
    logic in_ready;
    logic clr_step;
    logic trk_first;
    logic trk_eval;
    logic note_draw;
    logic note_write;
    logic note_take;
    logic stage_note;
    logic pos_start;
    logic pos_write;
    logic trk_next;
    logic finish;
  } mss_cmd_t;

  typedef struct packed {
    logic       in_tick;
    logic       master;
    logic       fire;
    logic       rand_sel;
    logic [1:0] dir;
    logic       rem_done;
    logic       out_free;
    logic       pend_valid;
    logic       clear_last;
    logic       last_trk;
  } mss_status_t;
endpackage
`default_nettype wire

// ===== hw/rtl/mss_rem.sv =====
// Bit-serial remainder unit: 32-bit dividend, 8-bit nonzero divisor.
// Depends on nothing; one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module mss_rem (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [31:0] dividend_i,
  input  wire logic [7:0]  divisor_i,
  output logic             done_o,
  output logic [7:0]       rem_o
);
  localparam logic [4:0] CNT_LAST = 5'd31;

  logic        busy_q, done_q;
  logic [4:0]  cnt_q;
  logic [31:0] dvd_q;
  logic [7:0]  div_q, rem_q, rem_d;
  logic [8:0]  trial;

  always_comb begin
    trial = {rem_q, dvd_q[31]};
    if (trial >= {1'b0, div_q}) begin
      rem_d = 8'(trial - {1'b0, div_q});
    end else begin
      rem_d = trial[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 5'd1;
      if (cnt_q == CNT_LAST) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      div_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[30:0], 1'b0};
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;
endmodule
`default_nettype wire

// ===== hw/rtl/mss_datapath.sv =====
// Datapath: configuration, track state, pattern memory, LFSR and result registers.
// Depends on mss_pkg and mss_rem.
`timescale 1ns / 1ps
`default_nettype none
module mss_datapath #(
  parameter int NUM_TRACKS      = 16,
  parameter int MAX_PATTERN_LEN = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire mss_pkg::mss_cmd_t     cmd_i,
  output mss_pkg::mss_status_t       status_o,
  input  wire logic                  cfg_valid_i,
  input  wire logic [2:0]            cfg_index_i,
  input  wire logic [31:0]           cfg_data_i,
  input  wire logic                  in_valid_i,
  input  wire logic [1:0]            action_i,
  input  wire logic [3:0]            track_i,
  input  wire logic [3:0]            step_slot_i,
  input  wire logic [4:0]            length_i,
  input  wire logic [5:0]            divide_i,
  input  wire logic [6:0]            note_range_i,
  input  wire logic [1:0]            direction_i,
  input  wire logic [6:0]            note_value_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic                       note_valid_o,
  output logic [3:0]                 out_track_o,
  output logic [6:0]                 note_o,
  output logic                       port_o,
  output logic                       clock_pulse_o,
  output logic [4:0]                 pulse_bus_o,
  output logic                       last_o
);
  import mss_pkg::*;

  localparam int TW    = (NUM_TRACKS > 1) ? $clog2(NUM_TRACKS) : 1;
  localparam int PW    = $clog2(MAX_PATTERN_LEN);
  localparam int LW    = $clog2(MAX_PATTERN_LEN + 1);
  localparam int DEPTH = NUM_TRACKS * MAX_PATTERN_LEN;
  localparam int AW    = $clog2(DEPTH);

  logic [15:0] interval_q, mask_q, tick_q, tick_inc;
  logic        rand_en_q, dest_q, master_q;
  logic [4:0]  clk_out_q;
  logic [31:0] lfsr_q, lfsr_next;

  logic [LW-1:0] len_q [NUM_TRACKS];
  logic [5:0]    div_q [NUM_TRACKS];
  logic [6:0]    range_q [NUM_TRACKS];
  logic [1:0]    dir_q [NUM_TRACKS];
  logic [PW-1:0] pos_q [NUM_TRACKS];
  logic [5:0]    dc_q [NUM_TRACKS];

  logic [TW-1:0] t_q;
  logic [AW-1:0] clr_q;
  logic [6:0]    mem [DEPTH];
  logic [6:0]    rdata_q, note_q;

  logic          pend_valid_q;
  logic [TW-1:0] pend_trk_q;
  logic [6:0]    pend_note_q;

  logic          accept, trk_ok, slot_ok;
  logic [31:0]   len_w, div_w;
  logic [LW-1:0] len_sat;
  logic [5:0]    div_sat, dc_inc;
  logic [LW-1:0] cur_len;
  logic [PW-1:0] cur_pos;
  logic [1:0]    cur_dir;
  logic [AW-1:0] rd_addr, in_addr, wr_addr;
  logic          we;
  logic [6:0]    wdata;
  logic          rem_start, rem_done, lfsr_adv;
  logic [31:0]   rem_dvd;
  logic [7:0]    rem_div, rem_res;
  logic          bus_ok, pulse, out_free, out_load;

  assign accept  = in_valid_i && cmd_i.in_ready;
  assign trk_ok  = 32'(track_i) < NUM_TRACKS;
  assign slot_ok = 32'(step_slot_i) < MAX_PATTERN_LEN;
  assign tick_inc = tick_q + 16'd1;

  always_comb begin
    len_w = 32'(length_i);
    if (len_w == 32'd0) len_w = 32'd1;
    if (len_w > MAX_PATTERN_LEN) len_w = 32'(MAX_PATTERN_LEN);
    len_sat = len_w[LW-1:0];
    div_w = 32'(divide_i);
    if (div_w == 32'd0) div_w = 32'd1;
    if (div_w > MAX_DIVIDE) div_w = 32'(MAX_DIVIDE);
    div_sat = div_w[5:0];
  end

  assign cur_len = len_q[t_q];
  assign cur_pos = pos_q[t_q];
  assign cur_dir = dir_q[t_q];
  assign dc_inc  = dc_q[t_q] + 6'd1;

  assign lfsr_next = (lfsr_q >> 1) ^ (lfsr_q[0] ? LFSR_TAPS : 32'd0);
  assign lfsr_adv  = cmd_i.note_draw || (cmd_i.pos_start && cur_dir == DIR_RND);
  assign rem_start = cmd_i.note_draw || (cmd_i.pos_start && cur_dir != DIR_HOLD);

  always_comb begin
    rem_div = 8'(cur_len);
    unique case (cur_dir)
      DIR_FWD: rem_dvd = 32'(cur_pos) + 32'd1;
      DIR_BWD: rem_dvd = 32'(cur_pos) + 32'(cur_len) - 32'd1;
      default: rem_dvd = lfsr_next;
    endcase
    if (cmd_i.note_draw) begin
      rem_dvd = lfsr_next;
      rem_div = {1'b0, range_q[t_q]} + 8'd1;
    end
  end

  mss_rem u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rem_start),
    .dividend_i (rem_dvd),
    .divisor_i  (rem_div),
    .done_o     (rem_done),
    .rem_o      (rem_res)
  );

  assign rd_addr = AW'(32'(t_q) * MAX_PATTERN_LEN + 32'(cur_pos));
  assign in_addr = AW'(32'(track_i) * MAX_PATTERN_LEN + 32'(step_slot_i));

  always_comb begin
    we      = 1'b0;
    wr_addr = in_addr;
    wdata   = note_value_i;
    priority if (cmd_i.clr_step) begin
      we      = 1'b1;
      wr_addr = clr_q;
      wdata   = '0;
    end else if (cmd_i.note_write) begin
      we      = 1'b1;
      wr_addr = rd_addr;
      wdata   = rem_res[6:0];
    end else if (accept && action_i == ACT_PATTERN && trk_ok && slot_ok) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[wr_addr] <= wdata;
    rdata_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q <= 16'd375;
      rand_en_q  <= 1'b0;
      mask_q     <= 16'hFFFF;
      dest_q     <= 1'b0;
      clk_out_q  <= 5'd1;
      lfsr_q     <= 32'd1;
      tick_q     <= '0;
      master_q   <= 1'b0;
      t_q        <= '0;
      clr_q      <= '0;
      for (int i = 0; i < NUM_TRACKS; i++) begin
        len_q[i]   <= LW'(MAX_PATTERN_LEN);
        div_q[i]   <= 6'd1;
        range_q[i] <= 7'd127;
        dir_q[i]   <= DIR_FWD;
        pos_q[i]   <= '0;
        dc_q[i]    <= '0;
      end
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          REG_INTERVAL: interval_q <= cfg_data_i[15:0];
          REG_RAND_EN:  rand_en_q  <= cfg_data_i[0];
          REG_MASK:     mask_q     <= cfg_data_i[15:0];
          REG_DEST:     dest_q     <= cfg_data_i[0];
          REG_CLK_OUT:  clk_out_q  <= cfg_data_i[4:0];
          REG_SEED:     lfsr_q     <= (cfg_data_i == 32'd0) ? 32'd1 : cfg_data_i;
          default: ;
        endcase
      end else if (lfsr_adv) begin
        lfsr_q <= lfsr_next;
      end
      if (cmd_i.clr_step) clr_q <= clr_q + AW'(1);
      if (accept && action_i == ACT_TICK) begin
        if (tick_inc < interval_q) begin
          tick_q   <= tick_inc;
          master_q <= 1'b0;
        end else begin
          tick_q   <= '0;
          master_q <= 1'b1;
        end
      end
      if (accept && action_i == ACT_TRACK && trk_ok) begin
        len_q[track_i[TW-1:0]]   <= len_sat;
        div_q[track_i[TW-1:0]]   <= div_sat;
        range_q[track_i[TW-1:0]] <= note_range_i;
        dir_q[track_i[TW-1:0]]   <= direction_i;
      end
      if (cmd_i.trk_first) t_q <= '0;
      if (cmd_i.trk_next) t_q <= t_q + TW'(1);
      if (cmd_i.trk_eval) dc_q[t_q] <= (dc_inc >= div_q[t_q]) ? 6'd0 : dc_inc;
      if (cmd_i.pos_write) pos_q[t_q] <= rem_res[PW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.note_write) note_q <= rem_res[6:0];
    if (cmd_i.note_take) note_q <= rdata_q;
  end

  assign bus_ok   = clk_out_q >= 5'd1 && 32'(clk_out_q) <= MAX_BUS;
  assign pulse    = master_q && bus_ok;
  assign out_free = !out_valid_o || out_ready_i;
  assign out_load = (cmd_i.stage_note && pend_valid_q) || cmd_i.finish;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      out_valid_o  <= 1'b0;
    end else begin
      if (cmd_i.stage_note) pend_valid_q <= 1'b1;
      if (cmd_i.finish) pend_valid_q <= 1'b0;
      if (out_load) out_valid_o <= 1'b1;
      else if (out_ready_i) out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.stage_note) begin
      pend_trk_q  <= t_q;
      pend_note_q <= note_q;
    end
    if (out_load) begin
      note_valid_o  <= pend_valid_q;
      out_track_o   <= pend_valid_q ? 4'(pend_trk_q) : 4'd0;
      note_o        <= pend_valid_q ? pend_note_q : 7'd0;
      port_o        <= dest_q;
      clock_pulse_o <= cmd_i.finish && pulse;
      pulse_bus_o   <= (cmd_i.finish && pulse) ? clk_out_q - 5'd1 : 5'd0;
      last_o        <= cmd_i.finish;
    end
  end

  always_comb begin
    status_o.in_tick    = in_valid_i && action_i == ACT_TICK;
    status_o.master     = master_q;
    status_o.fire       = dc_inc >= div_q[t_q];
    status_o.rand_sel   = rand_en_q && mask_q[4'(t_q)];
    status_o.dir        = cur_dir;
    status_o.rem_done   = rem_done;
    status_o.out_free   = out_free;
    status_o.pend_valid = pend_valid_q;
    status_o.clear_last = clr_q == AW'(DEPTH - 1);
    status_o.last_trk   = t_q == TW'(NUM_TRACKS - 1);
  end
endmodule
`default_nettype wire

// ===== hw/rtl/mss_ctrl.sv =====
// Controller state machine: memory clear, tick runs over all tracks, result ordering.
// Depends on mss_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mss_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire mss_pkg::mss_status_t status_i,
  output mss_pkg::mss_cmd_t         cmd_o
);
  import mss_pkg::*;

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_TCHK   = 4'd2;
  localparam logic [3:0] S_TEVAL  = 4'd3;
  localparam logic [3:0] S_NWAIT  = 4'd4;
  localparam logic [3:0] S_NREAD  = 4'd5;
  localparam logic [3:0] S_NOUT   = 4'd6;
  localparam logic [3:0] S_PSTART = 4'd7;
  localparam logic [3:0] S_PWAIT  = 4'd8;
  localparam logic [3:0] S_NEXT   = 4'd9;
  localparam logic [3:0] S_FIN    = 4'd10;

  logic [3:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_CLEAR;
    else state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (status_i.clear_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (status_i.in_tick) state_d = S_TCHK;
      end
      S_TCHK: begin
        if (status_i.master) begin
          cmd_o.trk_first = 1'b1;
          state_d = S_TEVAL;
        end else begin
          state_d = S_FIN;
        end
      end
      S_TEVAL: begin
        cmd_o.trk_eval = 1'b1;
        if (status_i.fire) begin
          if (status_i.rand_sel) begin
            cmd_o.note_draw = 1'b1;
            state_d = S_NWAIT;
          end else begin
            state_d = S_NREAD;
          end
        end else begin
          state_d = S_NEXT;
        end
      end
      S_NWAIT: begin
        if (status_i.rem_done) begin
          cmd_o.note_write = 1'b1;
          state_d = S_NOUT;
        end
      end
      S_NREAD: begin
        cmd_o.note_take = 1'b1;
        state_d = S_NOUT;
      end
      S_NOUT: begin
        if (!status_i.pend_valid || status_i.out_free) begin
          cmd_o.stage_note = 1'b1;
          state_d = S_PSTART;
        end
      end
      S_PSTART: begin
        cmd_o.pos_start = 1'b1;
        state_d = (status_i.dir == DIR_HOLD) ? S_NEXT : S_PWAIT;
      end
      S_PWAIT: begin
        if (status_i.rem_done) begin
          cmd_o.pos_write = 1'b1;
          state_d = S_NEXT;
        end
      end
      S_NEXT: begin
        if (status_i.last_trk) begin
          state_d = S_FIN;
        end else begin
          cmd_o.trk_next = 1'b1;
          state_d = S_TEVAL;
        end
      end
      S_FIN: begin
        if (status_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// ===== hw/rtl/multitrack_step_sequencer_unit.sv =====
// Write items are taken in the idle state, which they do not leave. A tick without a master
// step passes the check and finish states and gives its result once the output is free. A master
// step visits each track; a firing one waits on the bit-serial remainder unit, run for a random
// note draw and for a position draw unless the track holds. After reset the pattern memory is
// cleared with in_ready_o low; configuration writes are taken at any time.
`timescale 1ns / 1ps
`default_nettype none
`include "multitrack_step_sequencer_unit_defines.svh"
module multitrack_step_sequencer_unit #(
  parameter int NUM_TRACKS      = mss_pkg::NUM_TRACKS_DEF,
  parameter int MAX_PATTERN_LEN = mss_pkg::MAX_PATTERN_LEN_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  action_i,
  input  wire logic [3:0]  track_i,
  input  wire logic [3:0]  step_slot_i,
  input  wire logic [4:0]  length_i,
  input  wire logic [5:0]  divide_i,
  input  wire logic [6:0]  note_range_i,
  input  wire logic [1:0]  direction_i,
  input  wire logic [6:0]  note_value_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             note_valid_o,
  output logic [3:0]       out_track_o,
  output logic [6:0]       note_o,
  output logic             port_o,
  output logic             clock_pulse_o,
  output logic [4:0]       pulse_bus_o,
  output logic             last_o
);
  import mss_pkg::*;

  mss_cmd_t    cmd;
  mss_status_t status;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = cmd.in_ready;

  mss_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .cmd_o    (cmd)
  );

  mss_datapath #(
    .NUM_TRACKS      (NUM_TRACKS),
    .MAX_PATTERN_LEN (MAX_PATTERN_LEN)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .action_i      (action_i),
    .track_i       (track_i),
    .step_slot_i   (step_slot_i),
    .length_i      (length_i),
    .divide_i      (divide_i),
    .note_range_i  (note_range_i),
    .direction_i   (direction_i),
    .note_value_i  (note_value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .note_valid_o  (note_valid_o),
    .out_track_o   (out_track_o),
    .note_o        (note_o),
    .port_o        (port_o),
    .clock_pulse_o (clock_pulse_o),
    .pulse_bus_o   (pulse_bus_o),
    .last_o        (last_o)
  );

  `MSS_ASSERT_IMP(a_empty_is_last, out_valid_o && !note_valid_o, last_o)
  `MSS_ASSERT_IMP(a_pulse_is_last, out_valid_o && clock_pulse_o, last_o)
  `MSS_ASSERT_IMP(a_idle_no_pending, cmd.in_ready, !status.pend_valid)
  `MSS_ASSERT_NEXT(a_finish_shows_last, cmd.finish, out_valid_o && last_o)
endmodule
`default_nettype wire
